@@ rtl/core/wast_pkg.sv @@
// Shared constants and types for the weight averaging filter with stability detection.
// Used by wast_alu and weight_average_with_stability; depends on nothing else.

package wast_pkg;

  // Ring size and the widths that follow from it.
  localparam int RING_DEPTH = 8;
  localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);

  // Field widths.
  localparam int WEIGHT_W   = 24;
  localparam int TIME_W     = 32;
  localparam int THR_W      = 23;
  localparam int HOLD_W     = 16;

  // Sum of a full ring, and the width of the shared adder.
  localparam int SUM_W      = WEIGHT_W + $clog2(RING_DEPTH);
  localparam int ALU_W      = (SUM_W > TIME_W) ? SUM_W + 2 : TIME_W + 2;
  localparam int DIV_CW     = $clog2(SUM_W);

  // Stream and configuration port widths.
  localparam int IN_DATA_W  = WEIGHT_W + TIME_W;
  localparam int OUT_DATA_W = WEIGHT_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = THR_W;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_JUMP_THRESHOLD = 2'd0,
    REG_STABLE_BAND    = 2'd1,
    REG_STABLE_HOLD    = 2'd2
  } reg_idx_t;

  // Result of the shared adder.
  typedef struct packed {
    logic                    neg;
    logic signed [ALU_W-1:0] sum;
  } alu_res_t;

endpackage

@@ rtl/core/wast_alu.sv @@
// Shared add/subtract unit used by the sequencer for its sum, divide, difference and compare steps.
// Depends on wast_pkg for its width and result type.

module wast_alu (
  input  logic signed [wast_pkg::ALU_W-1:0] op_a,
  input  logic signed [wast_pkg::ALU_W-1:0] op_b,
  input  logic                              sub,
  output wast_pkg::alu_res_t                res
);

  logic [wast_pkg::ALU_W-1:0] b_eff;
  logic [wast_pkg::ALU_W-1:0] sum;

  // Subtraction is the sum with the inverted operand plus one.
  assign b_eff   = sub ? ~op_b : op_b;
  assign sum     = op_a + b_eff + wast_pkg::ALU_W'(sub);
  assign res.sum = sum;
  assign res.neg = sum[wast_pkg::ALU_W-1];

endmodule

@@ rtl/core/weight_average_with_stability.sv @@
// Each accepted item is processed by a small sequencer that drives one shared adder
// (wast_alu). A weight sample is stored in the ring, and the filled entries are summed
// and divided by their count; a sample that jumps past the threshold needs no sum, since
// the ring is refilled with it one entry per cycle. A tare item clears the filter and
// goes straight to the output. The time of a summed sample is set by the ring sum, which
// reads each entry in a read state and an accumulate state through the registered read
// port, and by the restoring divide, which produces one quotient bit per cycle over the
// sum width. The input is not ready while an item is in progress; a finished result
// waits in the output register, so the next item can be accepted before the result is taken.
// Depends on wast_pkg and wast_alu.

module weight_average_with_stability (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [wast_pkg::IN_DATA_W-1:0]      in_tdata,   // [23:0] weight, [55:24] time_ms
  input  logic                                in_tuser,   // [0] kind (1 = tare)
  // Result stream.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [wast_pkg::OUT_DATA_W-1:0]     out_tdata,  // [23:0] filtered_weight
  output logic                                out_tuser,  // [0] stable
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [wast_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wast_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int AW   = wast_pkg::RING_AW;
  localparam int CW   = wast_pkg::CNT_W;
  localparam int WW   = wast_pkg::WEIGHT_W;
  localparam int TW   = wast_pkg::TIME_W;
  localparam int SW   = wast_pkg::SUM_W;
  localparam int ALW  = wast_pkg::ALU_W;
  localparam int DCW  = wast_pkg::DIV_CW;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_JDIFF,
    ST_JABS,
    ST_JCMP,
    ST_FILL,
    ST_WRITE,
    ST_READ,
    ST_ACC,
    ST_DSETUP,
    ST_DIV,
    ST_DSIGN,
    ST_BDIFF,
    ST_BABS,
    ST_BCMP,
    ST_TSUB,
    ST_TCMP,
    ST_OUT
  } state_t;

  // Control state.
  state_t                  state_r, state_nxt;
  logic [AW-1:0]           write_slot_r, write_slot_nxt;
  logic [CW-1:0]           fill_count_r, fill_count_nxt;
  logic signed [WW-1:0]    avg_r, avg_nxt;
  logic signed [WW-1:0]    ref_r, ref_nxt;
  logic [TW-1:0]           settle_r, settle_nxt;
  logic                    mark_r, mark_nxt;
  logic                    out_tvalid_r, out_tvalid_nxt;

  // Configuration registers.
  logic [wast_pkg::THR_W-1:0]  jump_thr_r;
  logic [wast_pkg::THR_W-1:0]  band_r;
  logic [wast_pkg::HOLD_W-1:0] hold_r;

  // Working registers.
  logic signed [WW-1:0]    w_r;
  logic [TW-1:0]           now_r;
  logic signed [ALW-1:0]   t_r, t_nxt;
  logic signed [SW-1:0]    acc_r, acc_nxt;
  logic [CW-1:0]           rem_r, rem_nxt;
  logic                    neg_r, neg_nxt;
  logic [AW-1:0]           idx_r, idx_nxt;
  logic [DCW-1:0]          bitcnt_r, bitcnt_nxt;
  logic signed [WW-1:0]    rdata_r;
  logic [wast_pkg::OUT_DATA_W-1:0] out_tdata_r;
  logic                    out_tuser_r;

  // Ring storage.
  logic signed [WW-1:0]    ring_mem [wast_pkg::RING_DEPTH];
  logic                    ring_we;
  logic [AW-1:0]           ring_waddr;

  // Shared adder connections.
  logic signed [ALW-1:0]   alu_a;
  logic signed [ALW-1:0]   alu_b;
  logic                    alu_sub;
  wast_pkg::alu_res_t      alu_res;

  logic                    in_xfer;
  logic                    out_load;
  logic [CW-1:0]           ws_inc;
  logic [CW:0]             rem_sh;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  assign ws_inc = CW'(write_slot_r) + CW'(1);
  assign rem_sh = {rem_r, acc_r[SW-1]};

  wast_alu u_alu (
    .op_a (alu_a),
    .op_b (alu_b),
    .sub  (alu_sub),
    .res  (alu_res)
  );

  // Sequencer: chooses the adder operands and the next value of every register.
  always_comb begin
    state_nxt      = state_r;
    write_slot_nxt = write_slot_r;
    fill_count_nxt = fill_count_r;
    avg_nxt        = avg_r;
    ref_nxt        = ref_r;
    settle_nxt     = settle_r;
    mark_nxt       = mark_r;
    t_nxt          = t_r;
    acc_nxt        = acc_r;
    rem_nxt        = rem_r;
    neg_nxt        = neg_r;
    idx_nxt        = idx_r;
    bitcnt_nxt     = bitcnt_r;
    alu_a          = '0;
    alu_b          = '0;
    alu_sub        = 1'b1;
    ring_we        = 1'b0;
    ring_waddr     = write_slot_r;
    out_load       = 1'b0;
    out_tvalid_nxt = out_tvalid_r && !out_tready;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser) begin
            write_slot_nxt = '0;
            fill_count_nxt = '0;
            avg_nxt        = '0;
            mark_nxt       = 1'b0;
            state_nxt      = ST_OUT;
          end else begin
            state_nxt = ST_JDIFF;
          end
        end
      end

      // Jump test: distance of the sample from the current average.
      ST_JDIFF: begin
        if (fill_count_r == '0) begin
          state_nxt = ST_WRITE;
        end else begin
          alu_a     = ALW'(w_r);
          alu_b     = ALW'(avg_r);
          t_nxt     = alu_res.sum;
          state_nxt = ST_JABS;
        end
      end

      ST_JABS: begin
        alu_b = t_r;
        if (t_r[ALW-1]) begin
          t_nxt = alu_res.sum;
        end
        state_nxt = ST_JCMP;
      end

      ST_JCMP: begin
        alu_a = ALW'(jump_thr_r);
        alu_b = t_r;
        if (alu_res.neg) begin
          idx_nxt   = '0;
          state_nxt = ST_FILL;
        end else begin
          state_nxt = ST_WRITE;
        end
      end

      // Refill every ring entry with the sample, one entry per cycle.
      ST_FILL: begin
        ring_we    = 1'b1;
        ring_waddr = idx_r;
        idx_nxt    = idx_r + AW'(1);
        if (idx_r == AW'(wast_pkg::RING_DEPTH - 1)) begin
          write_slot_nxt = '0;
          fill_count_nxt = CW'(wast_pkg::RING_DEPTH);
          avg_nxt        = w_r;
          state_nxt      = ST_BDIFF;
        end
      end

      // Store the sample at the write slot and start the sum.
      ST_WRITE: begin
        ring_we        = 1'b1;
        ring_waddr     = write_slot_r;
        write_slot_nxt = (ws_inc >= CW'(wast_pkg::RING_DEPTH)) ? '0 : ws_inc[AW-1:0];
        if (fill_count_r < CW'(wast_pkg::RING_DEPTH)) begin
          fill_count_nxt = fill_count_r + CW'(1);
        end
        acc_nxt   = '0;
        idx_nxt   = '0;
        state_nxt = ST_READ;
      end

      ST_READ: begin
        state_nxt = ST_ACC;
      end

      ST_ACC: begin
        alu_a   = ALW'(acc_r);
        alu_b   = ALW'(rdata_r);
        alu_sub = 1'b0;
        acc_nxt = alu_res.sum[SW-1:0];
        idx_nxt = idx_r + AW'(1);
        if ((CW'(idx_r) + CW'(1)) < fill_count_r) begin
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_DSETUP;
        end
      end

      // Take the magnitude of the sum and start the restoring divide.
      ST_DSETUP: begin
        alu_b   = ALW'(acc_r);
        neg_nxt = acc_r[SW-1];
        if (acc_r[SW-1]) begin
          acc_nxt = alu_res.sum[SW-1:0];
        end
        rem_nxt    = '0;
        bitcnt_nxt = DCW'(SW - 1);
        state_nxt  = ST_DIV;
      end

      // One quotient bit per cycle; the quotient shifts into the sum register.
      ST_DIV: begin
        alu_a      = ALW'(rem_sh);
        alu_b      = ALW'(fill_count_r);
        rem_nxt    = alu_res.neg ? rem_sh[CW-1:0] : alu_res.sum[CW-1:0];
        acc_nxt    = {acc_r[SW-2:0], !alu_res.neg};
        bitcnt_nxt = bitcnt_r - DCW'(1);
        if (bitcnt_r == '0) begin
          state_nxt = ST_DSIGN;
        end
      end

      // Restore the sign of the truncated quotient.
      ST_DSIGN: begin
        alu_b     = ALW'($unsigned(acc_r));
        avg_nxt   = neg_r ? alu_res.sum[WW-1:0] : acc_r[WW-1:0];
        state_nxt = ST_BDIFF;
      end

      // Band test: drift of the average from the reference.
      ST_BDIFF: begin
        alu_a     = ALW'(avg_r);
        alu_b     = ALW'(ref_r);
        t_nxt     = alu_res.sum;
        state_nxt = ST_BABS;
      end

      ST_BABS: begin
        alu_b = t_r;
        if (t_r[ALW-1]) begin
          t_nxt = alu_res.sum;
        end
        state_nxt = ST_BCMP;
      end

      ST_BCMP: begin
        alu_a = ALW'(band_r);
        alu_b = t_r;
        if (alu_res.neg) begin
          ref_nxt    = avg_r;
          settle_nxt = now_r;
          mark_nxt   = 1'b0;
          state_nxt  = ST_OUT;
        end else if (!mark_r) begin
          state_nxt = ST_TSUB;
        end else begin
          state_nxt = ST_OUT;
        end
      end

      // Elapsed time since the reference was set, modulo the timestamp width.
      ST_TSUB: begin
        alu_a     = ALW'(now_r);
        alu_b     = ALW'(settle_r);
        t_nxt     = ALW'(alu_res.sum[TW-1:0]);
        state_nxt = ST_TCMP;
      end

      ST_TCMP: begin
        alu_a = ALW'(hold_r);
        alu_b = t_r;
        if (alu_res.neg) begin
          mark_nxt = 1'b1;
        end
        state_nxt = ST_OUT;
      end

      // Hand the result to the output register once it is free.
      ST_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_load       = 1'b1;
          out_tvalid_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      write_slot_r <= '0;
      fill_count_r <= '0;
      avg_r        <= '0;
      ref_r        <= '0;
      settle_r     <= '0;
      mark_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
      out_tdata_r  <= '0;
      out_tuser_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      write_slot_r <= write_slot_nxt;
      fill_count_r <= fill_count_nxt;
      avg_r        <= avg_nxt;
      ref_r        <= ref_nxt;
      settle_r     <= settle_nxt;
      mark_r       <= mark_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (out_load) begin
        out_tdata_r <= avg_r;
        out_tuser_r <= mark_r;
      end
    end
  end

  // Configuration register writes; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jump_thr_r <= wast_pkg::THR_W'(2000);
      band_r     <= wast_pkg::THR_W'(50);
      hold_r     <= wast_pkg::HOLD_W'(1000);
    end else if (cfg_we) begin
      unique case (wast_pkg::reg_idx_t'(cfg_index))
        wast_pkg::REG_JUMP_THRESHOLD: jump_thr_r <= cfg_wdata;
        wast_pkg::REG_STABLE_BAND:    band_r     <= cfg_wdata;
        wast_pkg::REG_STABLE_HOLD:    hold_r     <= cfg_wdata[wast_pkg::HOLD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      w_r   <= in_tdata[WW-1:0];
      now_r <= in_tdata[WW+TW-1:WW];
    end
    t_r      <= t_nxt;
    acc_r    <= acc_nxt;
    rem_r    <= rem_nxt;
    neg_r    <= neg_nxt;
    idx_r    <= idx_nxt;
    bitcnt_r <= bitcnt_nxt;
  end

  // Ring memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ring_waddr] <= w_r;
    end
    rdata_r <= ring_mem[idx_r];
  end

  // An accepted item always keeps the input busy for at least the next cycle.
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready)
    else $error("input ready right after a transfer");

  // The fill count never exceeds the ring depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_count_r <= CW'(wast_pkg::RING_DEPTH))
    else $error("fill count beyond ring depth");

  // The write slot always points inside the ring.
  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(write_slot_r) < CW'(wast_pkg::RING_DEPTH))
    else $error("write slot outside the ring");

  // A tare clears the filter and the stable flag at once.
  a_tare_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_tuser) |=> (avg_r == '0 && !mark_r && fill_count_r == '0))
    else $error("tare did not clear the filter");

endmodule
